// ===== sv/rfft_pkg.sv =====
// rfft_pkg: shared constants and types for the radix-2 fft frame block
// depends on nothing; imported by rfft_front, rfft_core and radix2_fft_frame
`timescale 1ns / 1ps

package rfft_pkg;

  localparam int unsigned POINTS_DEF = 1024;
  localparam int unsigned TWB_DEF    = 18;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BIN_W      = 27;
  localparam int unsigned INDEX_W    = 10;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                        op;
    logic signed [SAMPLE_W-1:0]  re;
    logic signed [SAMPLE_W-1:0]  im;
  } cmd_t;

endpackage

// ===== sv/rfft_front.sv =====
// rfft_front: accepts input transactions, classifies them and queues them
// depends on rfft_pkg
`timescale 1ns / 1ps

module rfft_front
  import rfft_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic signed [SAMPLE_W-1:0] sample_re_i,
  input  logic signed [SAMPLE_W-1:0] sample_im_i,
  output logic                       cmd_valid_o,
  output cmd_t                       cmd_o,
  input  logic                       cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_in;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i & ~in_stall_o;
  assign pop         = cmd_pop_i & cmd_valid_o;

  always_comb begin
    cmd_in.op = (action_i == CMD_PULL) ? CMD_PULL : CMD_PUSH;
    cmd_in.re = sample_re_i;
    cmd_in.im = sample_im_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/rfft_core.sv =====
// rfft_core: frame store, butterfly sequencer and result register
// depends on rfft_pkg; fed by rfft_front
`timescale 1ns / 1ps

module rfft_core
  import rfft_pkg::*;
#(
  parameter int unsigned POINTS = POINTS_DEF,
  parameter int unsigned TWB    = TWB_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  cmd_t                     cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [BIN_W-1:0]  bin_re_o,
  output logic signed [BIN_W-1:0]  bin_im_o,
  output logic [INDEX_W-1:0]       bin_index_o,
  output logic                     last_bin_o,
  output logic                     no_data_o
);

  localparam int unsigned LOG      = $clog2(POINTS);
  localparam int unsigned TW_AW    = (LOG > 1) ? LOG - 1 : 1;
  localparam int unsigned TW_DEPTH = POINTS / 2;
  localparam int unsigned SW       = (LOG > 1) ? $clog2(LOG) : 1;
  localparam int unsigned FRAC     = TWB - 2;
  localparam int unsigned PW       = BIN_W + TWB;
  localparam int unsigned EW       = 2 * BIN_W;
  localparam real         INV_N    = 1.0 / POINTS;
  localparam real         TWO_PI   = 6.283185307179586;
  localparam logic signed [PW:0] RND_C = (PW+1)'(1) << (FRAC - 1);

  typedef logic [2*TWB-1:0] tw_tab_t [TW_DEPTH];

  function automatic logic [TWB-1:0] tw_round(input real v);
    real    mag;
    longint r;
    mag = (v < 0.0) ? -v : v;
    r   = longint'($floor(mag * (2.0 ** FRAC) + 0.5));
    if (v < 0.0) r = -r;
    return TWB'(r);
  endfunction

  function automatic tw_tab_t build_tw();
    tw_tab_t t;
    real     ang;
    for (int k = 0; k < TW_DEPTH; k++) begin
      ang  = TWO_PI * k * INV_N;
      t[k] = {tw_round($cos(ang)), tw_round(-$sin(ang))};
    end
    return t;
  endfunction

  localparam tw_tab_t TW_TABLE = build_tw();

  function automatic logic [LOG-1:0] bitrev(input logic [LOG-1:0] v);
    logic [LOG-1:0] r;
    for (int i = 0; i < LOG; i++) begin
      r[i] = v[LOG-1-i];
    end
    return r;
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BRD  = 6'b000010,
    ST_BMUL = 6'b000100,
    ST_BADD = 6'b001000,
    ST_BWR  = 6'b010000,
    ST_PULL = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic [LOG-1:0] load_cnt_q, load_cnt_d;
  logic [LOG-1:0] pull_pos_q, pull_pos_d;
  logic           held_q, held_d;
  logic [SW-1:0]  st_q, st_d;
  logic [TW_AW-1:0] bf_q, bf_d;
  logic           out_valid_q, out_valid_d;

  logic [EW-1:0]  mem [POINTS];
  logic           we;
  logic [LOG-1:0] waddr;
  logic [EW-1:0]  wdata;
  logic           rd_en;
  logic [LOG-1:0] ra, rb;
  logic [TW_AW-1:0] wi;
  logic [EW-1:0]  a_q, b_q;
  logic [2*TWB-1:0] tw_q;
  logic [EW-1:0]  hi_q, hi_d;
  logic           hi_en;

  logic signed [PW-1:0] p_rr_q, p_mm_q, p_rm_q, p_mr_q;
  logic                 mul_en;

  logic                       out_load, out_nd_d, out_last_d;
  logic signed [BIN_W-1:0]    out_re_d, out_im_d, out_re_q, out_im_q;
  logic [INDEX_W-1:0]         out_idx_d, out_idx_q;
  logic                       out_nd_q, out_last_q;

  logic [LOG-1:0] bl, mask, lo_addr, hi_addr, load_idx;
  logic signed [PW:0] tr_full, tm_full, tr_sh, tm_sh;
  logic signed [BIN_W-1:0] tr, tm, ur, um;
  logic [EW-1:0] lo_val;
  logic out_free;

  always_comb begin
    bl      = LOG'(bf_q);
    mask    = (LOG'(1) << st_q) - LOG'(1);
    lo_addr = ((bl & ~mask) << 1) | (bl & mask);
    hi_addr = lo_addr | (LOG'(1) << st_q);
    wi      = TW_AW'((bl & mask) << (LOG - 1 - st_q));
  end

  always_comb begin
    ur      = a_q[EW-1:BIN_W];
    um      = a_q[BIN_W-1:0];
    tr_full = (PW+1)'(p_rr_q) - (PW+1)'(p_mm_q) + RND_C;
    tm_full = (PW+1)'(p_rm_q) + (PW+1)'(p_mr_q) + RND_C;
    tr_sh   = tr_full >>> FRAC;
    tm_sh   = tm_full >>> FRAC;
    tr      = tr_sh[BIN_W-1:0];
    tm      = tm_sh[BIN_W-1:0];
    lo_val  = {ur + tr, um + tm};
    hi_d    = {ur - tr, um - tm};
  end

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign load_idx = held_q ? '0 : load_cnt_q;

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    pull_pos_d  = pull_pos_q;
    held_d      = held_q;
    st_d        = st_q;
    bf_d        = bf_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = lo_addr;
    wdata       = lo_val;
    rd_en       = 1'b0;
    ra          = lo_addr;
    rb          = hi_addr;
    mul_en      = 1'b0;
    hi_en       = 1'b0;
    out_load    = 1'b0;
    out_re_d    = '0;
    out_im_d    = '0;
    out_idx_d   = '0;
    out_last_d  = 1'b0;
    out_nd_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == CMD_PUSH) begin
            cmd_pop_o = 1'b1;
            we        = 1'b1;
            waddr     = bitrev(load_idx);
            wdata     = {BIN_W'(cmd_i.re), BIN_W'(cmd_i.im)};
            held_d    = 1'b0;
            pull_pos_d = '0;
            if (load_idx == LOG'(POINTS - 1)) begin
              load_cnt_d = '0;
              st_d       = '0;
              bf_d       = '0;
              state_d    = ST_BRD;
            end else begin
              load_cnt_d = load_idx + LOG'(1);
            end
          end else if (!held_q) begin
            if (out_free) begin
              cmd_pop_o   = 1'b1;
              out_load    = 1'b1;
              out_nd_d    = 1'b1;
              out_valid_d = 1'b1;
            end
          end else if (!out_valid_q) begin
            cmd_pop_o = 1'b1;
            rd_en     = 1'b1;
            ra        = pull_pos_q;
            state_d   = ST_PULL;
          end
        end
      end
      ST_PULL: begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        out_re_d    = a_q[EW-1:BIN_W];
        out_im_d    = a_q[BIN_W-1:0];
        out_idx_d   = INDEX_W'(pull_pos_q);
        out_last_d  = (pull_pos_q == LOG'(POINTS - 1));
        pull_pos_d  = pull_pos_q + LOG'(1);
        if (out_last_d) begin
          held_d = 1'b0;
        end
        state_d = ST_IDLE;
      end
      ST_BRD: begin
        rd_en   = 1'b1;
        state_d = ST_BMUL;
      end
      ST_BMUL: begin
        mul_en  = 1'b1;
        state_d = ST_BADD;
      end
      ST_BADD: begin
        we      = 1'b1;
        hi_en   = 1'b1;
        state_d = ST_BWR;
      end
      ST_BWR: begin
        we      = 1'b1;
        waddr   = hi_addr;
        wdata   = hi_q;
        state_d = ST_BRD;
        if (bf_q == TW_AW'(TW_DEPTH - 1)) begin
          bf_d = '0;
          if (st_q == SW'(LOG - 1)) begin
            st_d       = '0;
            held_d     = 1'b1;
            pull_pos_d = '0;
            state_d    = ST_IDLE;
          end else begin
            st_d = st_q + SW'(1);
          end
        end else begin
          bf_d = bf_q + TW_AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_cnt_q  <= '0;
      pull_pos_q  <= '0;
      held_q      <= 1'b0;
      st_q        <= '0;
      bf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      pull_pos_q  <= pull_pos_d;
      held_q      <= held_d;
      st_q        <= st_d;
      bf_q        <= bf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      a_q  <= mem[ra];
      b_q  <= mem[rb];
      tw_q <= TW_TABLE[wi];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_rr_q <= $signed(b_q[EW-1:BIN_W]) * $signed(tw_q[2*TWB-1:TWB]);
      p_mm_q <= $signed(b_q[BIN_W-1:0])  * $signed(tw_q[TWB-1:0]);
      p_rm_q <= $signed(b_q[EW-1:BIN_W]) * $signed(tw_q[TWB-1:0]);
      p_mr_q <= $signed(b_q[BIN_W-1:0])  * $signed(tw_q[2*TWB-1:TWB]);
    end
    if (hi_en) begin
      hi_q <= hi_d;
    end
    if (out_load) begin
      out_re_q   <= out_re_d;
      out_im_q   <= out_im_d;
      out_idx_q  <= out_idx_d;
      out_last_q <= out_last_d;
      out_nd_q   <= out_nd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_re_o    = out_re_q;
  assign bin_im_o    = out_im_q;
  assign bin_index_o = out_idx_q;
  assign last_bin_o  = out_last_q;
  assign no_data_o   = out_nd_q;

endmodule

// ===== sv/radix2_fft_frame.sv =====
// radix2_fft_frame: top level of the framed radix-2 decimation-in-time fft
// depends on rfft_pkg, rfft_front and rfft_core
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i/in_stall_o   | action_i, sample_re_i, sample_im_i
//   out     | output    | out_valid_o/out_stall_i | bin_re_o, bin_im_o, bin_index_o,
//           |           |                         | last_bin_o, no_data_o
//
// a push is written straight to the frame store, a no_data pull loads the output register,
// a pull reads its bin from the store before loading it, and a pull waits until the
// previous bin has left the output register; the last push of a frame starts the transform,
// each butterfly going through read, multiply, add and write states on the single-write frame store
// reset clears counters and flags only; the frame store needs no clearing
// a two-entry queue keeps taking transactions while the core is busy or stalled, until it is full
`timescale 1ns / 1ps

module radix2_fft_frame
  import rfft_pkg::*;
#(
  parameter int unsigned POINTS       = POINTS_DEF,
  parameter int unsigned TWIDDLE_BITS = TWB_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic signed [SAMPLE_W-1:0] sample_re_i,
  input  logic signed [SAMPLE_W-1:0] sample_im_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [BIN_W-1:0]    bin_re_o,
  output logic signed [BIN_W-1:0]    bin_im_o,
  output logic [INDEX_W-1:0]         bin_index_o,
  output logic                       last_bin_o,
  output logic                       no_data_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  rfft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rfft_core #(
    .POINTS (POINTS),
    .TWB    (TWIDDLE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bin_re_o    (bin_re_o),
    .bin_im_o    (bin_im_o),
    .bin_index_o (bin_index_o),
    .last_bin_o  (last_bin_o),
    .no_data_o   (no_data_o)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for radix2_fft_frame, a framed radix-2 fft
// depends on rfft_pkg and radix2_fft_frame; a local transform model predicts each bin
`timescale 1ns / 1ps

module testbench;
  import rfft_pkg::*;

  localparam int NPTS = 1024;
  localparam int HALF = NPTS / 2;
  localparam int LOGN = 10;
  localparam int FRAC = 16;
  localparam longint unsigned ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam longint unsigned TWO_PI_Q61 = 64'hC90F_DAA2_2168_C235;

  typedef struct {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [INDEX_W-1:0]      idx;
    logic                    last;
    logic                    nodata;
  } bin_t;

  typedef struct {
    cmd_e        op;
    int          re;
    int          im;
    bit          typed;
    bin_t        res;
  } row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       action_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_re_i = '0;
  logic signed [SAMPLE_W-1:0] sample_im_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [BIN_W-1:0]    bin_re_o;
  logic signed [BIN_W-1:0]    bin_im_o;
  logic [INDEX_W-1:0]         bin_index_o;
  logic                       last_bin_o;
  logic                       no_data_o;

  radix2_fft_frame u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .sample_re_i, .sample_im_i,
    .out_valid_o, .out_stall_i, .bin_re_o, .bin_im_o, .bin_index_o, .last_bin_o,
    .no_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #16_000_000;
    $display("FAILURE");
    $finish;
  end

  // spectrum model state
  int   tw_re[HALF];
  int   tw_im[HALF];
  int   frame_re[NPTS];
  int   frame_im[NPTS];
  int   load_cnt;
  int   pull_pos;
  bit   bins_ready;
  bin_t pending_bins[$];
  int   errors;
  int   phase;
  bit   hold_req;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic void base_cs(longint unsigned phi, output longint unsigned c,
                                  output longint unsigned s);
    logic [127:0]    p;
    longint unsigned x, x2, term, sum;
    int              n;
    p = {64'd0, phi} * {64'd0, TWO_PI_Q61};
    x = p[94:31];
    x2 = qmul(x, x);
    sum = ONE_Q62; term = ONE_Q62; n = 0;
    for (int i = 0; i < 40; i++) begin
      term = qmul(term, x2) / longint'((n + 1) * (n + 2));
      n += 2;
      if (term == 0) break;
      if (((n / 2) & 1) != 0) sum -= term; else sum += term;
    end
    c = sum;
    sum = x; term = x; n = 1;
    for (int i = 0; i < 40; i++) begin
      term = qmul(term, x2) / longint'((n + 1) * (n + 2));
      n += 2;
      if (term == 0) break;
      if (((n / 2) & 1) != 0) sum -= term; else sum += term;
    end
    s = sum;
  endfunction

  function automatic int round_twiddle(longint unsigned mag, bit neg);
    longint unsigned r;
    r = (mag + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    return neg ? -int'(r) : int'(r);
  endfunction

  function automatic void build_twiddles();
    longint unsigned t, r, c, s, cm, sm;
    int              oct;
    bit              cneg, sneg;
    for (int k = 0; k < HALF; k++) begin
      t = (longint'(k) << 32) / NPTS;
      oct = int'((t >> 29) & 7);
      r = t & ((64'd1 << 29) - 1);
      base_cs(oct[0] ? ((64'd1 << 29) - r) : r, c, s);
      case (oct)
        0: begin cm = c; sm = s; cneg = 0; sneg = 0; end
        1: begin cm = s; sm = c; cneg = 0; sneg = 0; end
        2: begin cm = s; sm = c; cneg = 1; sneg = 0; end
        3: begin cm = c; sm = s; cneg = 1; sneg = 0; end
        4: begin cm = c; sm = s; cneg = 1; sneg = 1; end
        5: begin cm = s; sm = c; cneg = 1; sneg = 1; end
        6: begin cm = s; sm = c; cneg = 0; sneg = 1; end
        default: begin cm = c; sm = s; cneg = 0; sneg = 1; end
      endcase
      tw_re[k] = round_twiddle(cm, cneg);
      tw_im[k] = round_twiddle(sm, !sneg);
    end
  endfunction

  function automatic int wrap_bin(longint v);
    logic signed [BIN_W-1:0] w;
    w = v[BIN_W-1:0];
    return int'(w);
  endfunction

  function automatic void run_fft();
    int     j, tmp, half, stride, lo, hi, wi;
    longint wr, wm, br, bm, tr, tm, ur, um;
    for (int i = 0; i < NPTS; i++) begin
      j = 0;
      for (int b = 0; b < LOGN; b++) j = (j << 1) | ((i >> b) & 1);
      if (i < j) begin
        tmp = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = tmp;
        tmp = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = tmp;
      end
    end
    for (int s = 2; s <= NPTS; s *= 2) begin
      half = s / 2;
      stride = NPTS / s;
      for (int k = 0; k + s <= NPTS; k += s) begin
        for (int m = 0; m < half; m++) begin
          lo = k + m; hi = k + m + half;
          wi = (m * stride) % HALF;
          wr = tw_re[wi]; wm = tw_im[wi];
          br = frame_re[hi]; bm = frame_im[hi];
          tr = (br * wr - bm * wm + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
          tm = (br * wm + bm * wr + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
          ur = frame_re[lo]; um = frame_im[lo];
          frame_re[lo] = wrap_bin(ur + tr);
          frame_im[lo] = wrap_bin(um + tm);
          frame_re[hi] = wrap_bin(ur - tr);
          frame_im[hi] = wrap_bin(um - tm);
        end
      end
    end
  endfunction

  function automatic bit predict_bin(cmd_e op, int re, int im, output bin_t res);
    res = '{default: '0};
    if (op == CMD_PUSH) begin
      if (bins_ready) begin
        bins_ready = 0; pull_pos = 0; load_cnt = 0;
      end
      frame_re[load_cnt] = re;
      frame_im[load_cnt] = im;
      load_cnt++;
      if (load_cnt >= NPTS) begin
        run_fft();
        bins_ready = 1; load_cnt = 0; pull_pos = 0;
      end
      return 0;
    end
    if (!bins_ready) begin
      res.nodata = 1'b1;
      return 1;
    end
    res.re = frame_re[pull_pos];
    res.im = frame_im[pull_pos];
    res.idx = pull_pos[INDEX_W-1:0];
    res.last = (pull_pos == NPTS - 1);
    pull_pos++;
    if (pull_pos >= NPTS) begin
      bins_ready = 0; pull_pos = 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  int items_sent;

  task automatic send(cmd_e op, int re, int im, bit typed, bin_t typed_res);
    bin_t res;
    int   gap;
    int   pct;
    pct = (phase == 0) ? 33 : (phase == 1) ? 80 : 0;
    if ($urandom_range(99) < pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= op;
    sample_re_i <= re[SAMPLE_W-1:0];
    sample_im_i <= im[SAMPLE_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    if (predict_bin(op, re, im, res)) pending_bins.push_back(typed ? typed_res : res);
    items_sent++;
    if (items_sent == 520) phase = 1;
    if (items_sent == 1040) phase = 2;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(7))
      0: return 32767;
      1: return -32768;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // receiver side: stall pattern and bin checks
  initial begin
    bin_t e;
    int   pct;
    int   hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_bins.size() == 0) begin
          report_mismatch("bin transaction with nothing expected");
        end else begin
          e = pending_bins.pop_front();
          if (bin_re_o !== e.re) report_mismatch($sformatf("bin_re %0d exp %0d", bin_re_o, e.re));
          if (bin_im_o !== e.im) report_mismatch($sformatf("bin_im %0d exp %0d", bin_im_o, e.im));
          if (bin_index_o !== e.idx)
            report_mismatch($sformatf("bin_index %0d exp %0d", bin_index_o, e.idx));
          if (last_bin_o !== e.last) report_mismatch("last_bin differs");
          if (no_data_o !== e.nodata) report_mismatch("no_data differs");
        end
      end
      if (hold_req && hold == 0) begin
        hold = 600;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        pct = (phase == 0) ? 80 : (phase == 1) ? 33 : 0;
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  row_t dir_rows[$];

  initial begin
    bin_t nd;
    bin_t none;
    int   waited;
    errors = 0; phase = 0; hold_req = 0; items_sent = 0;
    load_cnt = 0; pull_pos = 0; bins_ready = 0;
    build_twiddles();
    none = '{default: '0};
    nd = none;
    nd.nodata = 1'b1;
    dir_rows = '{
      '{CMD_PULL, 0, 0, 1, nd},
      '{CMD_PULL, 32767, -32768, 1, nd},
      '{CMD_PUSH, 32767, 32767, 0, none},
      '{CMD_PUSH, -32768, -32768, 0, none},
      '{CMD_PUSH, 32767, -32768, 0, none},
      '{CMD_PUSH, -32768, 32767, 0, none},
      '{CMD_PUSH, 0, 0, 0, none},
      '{CMD_PUSH, -1, -1, 0, none},
      '{CMD_PULL, 0, 0, 1, nd},
      '{CMD_PUSH, 1, 1, 0, none},
      '{CMD_PUSH, 21845, -21846, 0, none},
      '{CMD_PUSH, -21846, 21845, 0, none},
      '{CMD_PULL, -1, -1, 1, nd}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send(dir_rows[i].op, dir_rows[i].re, dir_rows[i].im, dir_rows[i].typed, dir_rows[i].res);
    // first frame, with stray pulls while loading
    while (!bins_ready) begin
      if ($urandom_range(19) == 0) send(CMD_PULL, rand_sample(), rand_sample(), 0, none);
      else send(CMD_PUSH, rand_sample(), rand_sample(), 0, none);
    end
    // pull bins, with a long output stall partway through
    for (int i = 0; i < 300; i++) begin
      if (i == 100) hold_req = 1;
      send(CMD_PULL, rand_sample(), rand_sample(), 0, none);
    end
    // sender pauses until every expected bin is back
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    // a push throws away the held bins and starts a new frame
    repeat (60) send(CMD_PUSH, rand_sample(), rand_sample(), 0, none);
    repeat (100) send(CMD_PULL, rand_sample(), rand_sample(), 0, none);
    in_valid_i <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < 100) begin
      @(posedge clk_i);
      waited++;
    end
    if (errors == 0 && pending_bins.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
